// ===== rtl/lbp_nr_uniform_3x3_core_defines.svh =====
// Assertion macros for the uniform LBP core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef LBP_NR_UNIFORM_3X3_CORE_DEFINES_SVH
`define LBP_NR_UNIFORM_3X3_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LBPNR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbp core check failed");
`define LBPNR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbp core check failed");
`else
`define LBPNR_ASSERT_NOW(label, clk, rst, ante, cons)
`define LBPNR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/lbpnr_pkg.sv =====
// Shared types, constants and the uniform label table of the LBP core.
// No dependencies.
package lbpnr_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 2048;
   localparam int MAX_HEIGHT_DEFAULT = 2048;

   localparam int PIX_W     = 8;
   localparam int LABEL_W   = 5;
   localparam int POS_W     = 11;
   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 2;
   localparam int CODE_W    = 7;

   localparam int LINE_WIDTH_RESET   = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_WIDTH     = 2'd0,
      CSR_FRAME_HEIGHT   = 2'd1,
      CSR_THRESHOLD_BIAS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   col;
      logic               last;
   } rsp_type;

   // position tag carried down the pipe alongside a pixel
   typedef struct packed {
      logic             emit;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } tag_type;

   localparam logic [LABEL_W-1:0] UNIFORM_MAP [128] = '{
      5'd1,  5'd2, 5'd3, 5'd4, 5'd5,  5'd0, 5'd6,  5'd7,
      5'd8,  5'd0, 5'd0, 5'd0, 5'd9,  5'd0, 5'd10, 5'd11,
      5'd12, 5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0,  5'd0,
      5'd13, 5'd0, 5'd0, 5'd0, 5'd14, 5'd0, 5'd15, 5'd16,
      5'd17, 5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0,  5'd0,
      5'd0,  5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0,  5'd0,
      5'd18, 5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0,  5'd0,
      5'd19, 5'd0, 5'd0, 5'd0, 5'd20, 5'd0, 5'd21, 5'd22,
      5'd23, 5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0,  5'd0,
      5'd0,  5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0,  5'd0,
      5'd0,  5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0,  5'd0,
      5'd0,  5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0,  5'd0,
      5'd24, 5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0,  5'd0,
      5'd0,  5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0,  5'd0,
      5'd25, 5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0,  5'd0,
      5'd26, 5'd0, 5'd0, 5'd0, 5'd27, 5'd0, 5'd28, 5'd29
   };

   function automatic logic [LABEL_W-1:0] uniform_label(input logic [CODE_W-1:0] code);
      return UNIFORM_MAP[code];
   endfunction

endpackage

// ===== rtl/lbpnr_line_mem.sv =====
// Combined two-line store: one synchronous RAM, entry = {upper, lower} pixel.
// Same-address bypass for a read that meets the write of the previous transfer.
// Depends on lbpnr_pkg.
module lbpnr_line_mem #(
   parameter int MAX_WIDTH = lbpnr_pkg::MAX_WIDTH_DEFAULT,
   localparam int ADDR_W   = $clog2(MAX_WIDTH),
   localparam int DATA_W   = 2 * lbpnr_pkg::PIX_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [MAX_WIDTH];
   logic [DATA_W-1:0] rd_q_ff;
   logic [DATA_W-1:0] byp_data_ff;
   logic              byp_ff;
   logic              byp_in;

   assign byp_in = rd_en && wr_en && (rd_addr == wr_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff     <= mem[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= byp_in;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_q_ff;

endmodule

// ===== rtl/lbpnr_code.sv =====
// Threshold, eight neighbour compares, fold and uniform label lookup.
// Depends on lbpnr_pkg.
module lbpnr_code (
   input  logic [3*lbpnr_pkg::PIX_W-1:0] win_top,
   input  logic [3*lbpnr_pkg::PIX_W-1:0] win_mid,
   input  logic [3*lbpnr_pkg::PIX_W-1:0] win_bot,
   input  logic [lbpnr_pkg::PIX_W-1:0]   bias,
   output logic [lbpnr_pkg::LABEL_W-1:0] label
);

   logic [lbpnr_pkg::PIX_W-1:0]  th;
   logic [7:0]                   code;
   logic [lbpnr_pkg::CODE_W-1:0] folded;

   always_comb begin
      th      = win_mid[15:8] + bias;
      code[7] = win_top[23:16] > th;
      code[6] = win_top[15:8]  > th;
      code[5] = win_top[7:0]   > th;
      code[4] = win_mid[23:16] > th;
      code[3] = win_mid[7:0]   > th;
      code[2] = win_bot[23:16] > th;
      code[1] = win_bot[15:8]  > th;
      code[0] = win_bot[7:0]   > th;
      // fold upper half: 255 - code is the bitwise complement
      folded  = code[7] ? ~code[6:0] : code[6:0];
      label   = lbpnr_pkg::uniform_label(folded);
   end

endmodule

// ===== rtl/lbpnr_rsp_queue.sv =====
// Small result queue between the window pipe and the output channel.
// Depends on lbpnr_pkg.
module lbpnr_rsp_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  lbpnr_pkg::rsp_type                push_data,
   input  logic                              pop,
   output lbpnr_pkg::rsp_type                head,
   output logic [lbpnr_pkg::RSP_CNT_W-1:0]   count
);

   lbpnr_pkg::rsp_type                  q_ff [lbpnr_pkg::RSP_DEPTH];
   logic [lbpnr_pkg::RSP_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [lbpnr_pkg::RSP_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [lbpnr_pkg::RSP_CNT_W-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + lbpnr_pkg::RSP_CNT_W'(push) - lbpnr_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = q_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

// ===== rtl/lbp_nr_uniform_3x3_core.sv =====
// Uniform LBP over a 3x3 window on a raster pixel stream. One pixel transfer
// per clock cycle is sustained while req_stall is low. Each pixel reads the
// two-line RAM at its column on acceptance, writes it back in stage 1 (a bypass
// covers a repeat of the same column), shifts the window, and its label enters
// a four-entry result queue. req_stall is high in reset, else only when that
// queue plus the results in flight would fill, i.e. when rsp_stall backs up.
// The line RAM needs no clearing after reset. Border pixels give no result.
// Geometry and bias registers may be written only while the core is idle.
`include "lbp_nr_uniform_3x3_core_defines.svh"
module lbp_nr_uniform_3x3_core #(
   parameter int MAX_WIDTH  = lbpnr_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = lbpnr_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lbpnr_pkg::PIX_W-1:0]           req_pixel,
   input  logic                                  req_frame_start,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lbpnr_pkg::LABEL_W-1:0]         rsp_pattern_label,
   output logic [lbpnr_pkg::POS_W-1:0]           rsp_centre_row,
   output logic [lbpnr_pkg::POS_W-1:0]           rsp_centre_col,
   output logic                                  rsp_frame_last,
   input  logic                                  csr_write_en,
   input  logic [lbpnr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lbpnr_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int EW = CW + 1;
   localparam int EH = RW + 1;
   localparam int PW = lbpnr_pkg::PIX_W;
   localparam int W_RESET = (lbpnr_pkg::LINE_WIDTH_RESET > MAX_WIDTH) ?
                            MAX_WIDTH : lbpnr_pkg::LINE_WIDTH_RESET;
   localparam int H_RESET = (lbpnr_pkg::FRAME_HEIGHT_RESET > MAX_HEIGHT) ?
                            MAX_HEIGHT : lbpnr_pkg::FRAME_HEIGHT_RESET;

   // configuration, geometry held already clamped to the store size
   logic [EW-1:0] eff_width_ff;
   logic [EH-1:0] eff_height_ff;
   logic [PW-1:0] bias_ff;
   logic [31:0]   wr_w32, wr_h32;

   always_comb begin
      wr_w32 = (32'(csr_wdata) > 32'(MAX_WIDTH))  ? 32'(MAX_WIDTH)  : 32'(csr_wdata);
      wr_h32 = (32'(csr_wdata) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(csr_wdata);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_width_ff  <= EW'(W_RESET);
         eff_height_ff <= EH'(H_RESET);
         bias_ff       <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            lbpnr_pkg::CSR_LINE_WIDTH: begin
               eff_width_ff <= wr_w32[EW-1:0];
            end
            lbpnr_pkg::CSR_FRAME_HEIGHT: begin
               eff_height_ff <= wr_h32[EH-1:0];
            end
            lbpnr_pkg::CSR_THRESHOLD_BIAS: begin
               bias_ff <= csr_wdata[PW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // acceptance stage: position counters
   logic              accept;
   logic [CW-1:0]     col_ff, col_in, col_cur;
   logic [RW-1:0]     row_ff, row_in, row_cur;
   logic [EW-1:0]     col_p1;
   logic [EH-1:0]     row_p1;
   logic              col_wrap;
   logic [31:0]       cm1_32, rm1_32;
   lbpnr_pkg::tag_type acc_tag;

   assign accept = req_valid && !req_stall;

   always_comb begin
      col_cur  = req_frame_start ? '0 : col_ff;
      row_cur  = req_frame_start ? '0 : row_ff;
      col_p1   = EW'(col_cur) + EW'(1);
      row_p1   = EH'(row_cur) + EH'(1);
      col_wrap = col_p1 >= eff_width_ff;
      if (col_wrap) begin
         col_in = '0;
         row_in = (row_p1 >= eff_height_ff) ? '0 : row_p1[RW-1:0];
      end else begin
         col_in = col_p1[CW-1:0];
         row_in = (EH'(row_cur) >= eff_height_ff) ? '0 : row_cur;
      end
      cm1_32       = 32'(col_cur) - 32'd1;
      rm1_32       = 32'(row_cur) - 32'd1;
      acc_tag.emit = (row_cur >= RW'(2)) && (col_cur >= CW'(2)) &&
                     (EH'(row_cur) < eff_height_ff) && (EW'(col_cur) < eff_width_ff);
      acc_tag.row  = rm1_32[lbpnr_pkg::POS_W-1:0];
      acc_tag.col  = cm1_32[lbpnr_pkg::POS_W-1:0];
      acc_tag.last = (row_p1 == eff_height_ff) && (col_p1 == eff_width_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1: RAM data back, write back and window shift
   logic               s1_valid_ff;
   lbpnr_pkg::tag_type s1_tag_ff;
   logic [PW-1:0]      s1_pixel_ff;
   logic [CW-1:0]      s1_col_ff;
   logic [2*PW-1:0]    rd_data;
   logic [2*PW-1:0]    wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tag_ff   <= acc_tag;
         s1_pixel_ff <= req_pixel;
         s1_col_ff   <= col_cur;
      end
   end

   // upper takes the old lower, lower takes the new pixel
   assign wr_data = {rd_data[PW-1:0], s1_pixel_ff};

   lbpnr_line_mem #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (rd_data),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data)
   );

   logic [3*PW-1:0] win_top_ff, win_mid_ff, win_bot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_top_ff <= '0;
         win_mid_ff <= '0;
         win_bot_ff <= '0;
      end else if (s1_valid_ff) begin
         win_top_ff <= {win_top_ff[2*PW-1:0], rd_data[2*PW-1:PW]};
         win_mid_ff <= {win_mid_ff[2*PW-1:0], rd_data[PW-1:0]};
         win_bot_ff <= {win_bot_ff[2*PW-1:0], s1_pixel_ff};
      end
   end

   // stage 2: label from the settled window
   logic               s2_emit_ff;
   lbpnr_pkg::tag_type s2_tag_ff;
   logic [lbpnr_pkg::LABEL_W-1:0] label;
   lbpnr_pkg::rsp_type push_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff <= 1'b0;
      end else begin
         s2_emit_ff <= s1_valid_ff && s1_tag_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_tag_ff <= s1_tag_ff;
      end
   end

   lbpnr_code u_code (
      .win_top (win_top_ff),
      .win_mid (win_mid_ff),
      .win_bot (win_bot_ff),
      .bias    (bias_ff),
      .label   (label)
   );

   always_comb begin
      push_data.label = label;
      push_data.row   = s2_tag_ff.row;
      push_data.col   = s2_tag_ff.col;
      push_data.last  = s2_tag_ff.last;
   end

   // result queue and flow control
   lbpnr_pkg::rsp_type                head;
   logic [lbpnr_pkg::RSP_CNT_W-1:0]   q_count;
   logic                              pop;
   logic [lbpnr_pkg::RSP_CNT_W:0]     pending;

   assign pop = rsp_valid && !rsp_stall;

   lbpnr_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_emit_ff),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .count     (q_count)
   );

   // hold off new transfers while the queue could not absorb what is in flight
   always_comb begin
      pending = (lbpnr_pkg::RSP_CNT_W + 1)'(q_count) +
                (lbpnr_pkg::RSP_CNT_W + 1)'(s1_valid_ff && s1_tag_ff.emit) +
                (lbpnr_pkg::RSP_CNT_W + 1)'(s2_emit_ff);
   end

   assign req_stall = reset || (pending >= (lbpnr_pkg::RSP_CNT_W + 1)'(lbpnr_pkg::RSP_DEPTH));

   assign rsp_valid         = q_count != '0;
   assign rsp_pattern_label = head.label;
   assign rsp_centre_row    = head.row;
   assign rsp_centre_col    = head.col;
   assign rsp_frame_last    = head.last;

   `LBPNR_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, pending <= (lbpnr_pkg::RSP_CNT_W + 1)'(lbpnr_pkg::RSP_DEPTH))
   `LBPNR_ASSERT_NOW(a_label_reaches_queue, clock, reset, $past(accept && acc_tag.emit, 3) && !$past(reset) && !$past(reset, 2), rsp_valid)
   `LBPNR_ASSERT_NOW(a_idle_not_stalled, clock, reset, pending == '0, !req_stall)

endmodule

// ===== dv/tb_lbp_nr_uniform_3x3_core.sv =====
// Self-checking bench for lbp_nr_uniform_3x3_core: pixel streams in, uniform LBP labels out.
// Labels are predicted in-bench from a line store and window model of its own.
// Depends on lbpnr_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_lbp_nr_uniform_3x3_core;
   import lbpnr_pkg::*;

   localparam int    SETTLE_CYCLES = 8;
   localparam int    DRAIN_LIMIT   = 20000;
   localparam int    RANDOM_QUOTA  = 240;
   localparam int    MAX_REPORTS   = 40;
   localparam int    STYLE_ANY     = 0;
   localparam int    STYLE_NEAR    = 1;
   localparam int    STYLE_BINARY  = 2;
   localparam longint TIMEOUT_NS   = 40_000_000;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_pixel       = '0;
   logic                 req_frame_start = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [LABEL_W-1:0]   rsp_pattern_label;
   logic [POS_W-1:0]     rsp_centre_row;
   logic [POS_W-1:0]     rsp_centre_col;
   logic                 rsp_frame_last;
   logic                 csr_write_en    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index       = CSR_LINE_WIDTH;
   logic [CSR_W-1:0]     csr_wdata       = '0;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int fault_count        = 0;

   // predicted core state
   int unsigned    cfg_line_width   = LINE_WIDTH_RESET;
   int unsigned    cfg_frame_height = FRAME_HEIGHT_RESET;
   logic [7:0]     cfg_bias         = '0;
   logic [PIX_W-1:0] store_upper [MAX_WIDTH_DEFAULT];
   logic [PIX_W-1:0] store_lower [MAX_WIDTH_DEFAULT];
   logic [23:0]    win_top = '0;
   logic [23:0]    win_mid = '0;
   logic [23:0]    win_bot = '0;
   int unsigned    next_col = 0;
   int unsigned    next_row = 0;
   rsp_type        pending_labels [$];

   lbp_nr_uniform_3x3_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel         (req_pixel),
      .req_frame_start   (req_frame_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pattern_label (rsp_pattern_label),
      .rsp_centre_row    (rsp_centre_row),
      .rsp_centre_col    (rsp_centre_col),
      .rsp_frame_last    (rsp_frame_last),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("** lbp_nr_uniform_3x3_core: FAILED **");
      $finish;
   end

   // Label = rank of the code among uniform codes (at most two circular bit changes), 0 otherwise.
   function automatic logic [LABEL_W-1:0] uniform_rank(input logic [6:0] code);
      int         rank;
      int         flips;
      logic [7:0] c;
      rank  = 0;
      flips = 0;
      for (int v = 0; v <= int'(code); v++) begin
         c     = 8'(v);
         flips = 0;
         for (int b = 0; b < 8; b++) begin
            if (c[b] != c[(b + 1) % 8]) flips++;
         end
         if (flips <= 2) rank++;
      end
      return (flips <= 2) ? LABEL_W'(rank) : '0;
   endfunction

   task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic first);
      int unsigned      w;
      int unsigned      h;
      int unsigned      col;
      int unsigned      row;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] lo;
      logic [PIX_W-1:0] thr;
      logic [7:0]       code;
      rsp_type          label_r;
      w = (cfg_line_width > MAX_WIDTH_DEFAULT) ? MAX_WIDTH_DEFAULT : cfg_line_width;
      h = (cfg_frame_height > MAX_HEIGHT_DEFAULT) ? MAX_HEIGHT_DEFAULT : cfg_frame_height;
      if (first) begin
         next_col = 0;
         next_row = 0;
      end
      col = next_col;
      row = next_row;
      if (col < MAX_WIDTH_DEFAULT) begin
         up               = store_upper[col];
         lo               = store_lower[col];
         store_upper[col] = lo;
         store_lower[col] = pix;
      end else begin
         up = '0;
         lo = '0;
      end
      win_top = {win_top[15:0], up};
      win_mid = {win_mid[15:0], lo};
      win_bot = {win_bot[15:0], pix};
      if (row >= 2 && col >= 2 && row < h && col < w) begin
         thr  = win_mid[15:8] + cfg_bias;
         code = {win_top[23:16] > thr, win_top[15:8] > thr, win_top[7:0] > thr,
                 win_mid[23:16] > thr, win_mid[7:0] > thr,
                 win_bot[23:16] > thr, win_bot[15:8] > thr, win_bot[7:0] > thr};
         // fold the upper half onto its complement
         if (code[7]) code = ~code;
         label_r.label = uniform_rank(code[6:0]);
         label_r.row   = POS_W'(row - 1);
         label_r.col   = POS_W'(col - 1);
         label_r.last  = (row + 1 == h) && (col + 1 == w);
         pending_labels.push_back(label_r);
      end
      if (col + 1 >= w) begin
         next_col = 0;
         next_row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
         next_col = col + 1;
         next_row = (row >= h) ? 0 : row;
      end
   endtask

   task automatic report_field(input string fname, input logic [31:0] expected_v,
                               input logic [31:0] actual_v);
      fault_count++;
      if (fault_count <= MAX_REPORTS)
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, expected_v, actual_v);
   endtask

   always @(posedge clock) begin : label_monitor
      rsp_type head_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_labels.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
               $display("%0t: unexpected label transfer: expected none, got label %0d at %0d,%0d",
                        $time, rsp_pattern_label, rsp_centre_row, rsp_centre_col);
         end else begin
            head_r = pending_labels.pop_front();
            if (rsp_pattern_label !== head_r.label)
               report_field("pattern_label", head_r.label, rsp_pattern_label);
            if (rsp_centre_row !== head_r.row)
               report_field("centre_row", head_r.row, rsp_centre_row);
            if (rsp_centre_col !== head_r.col)
               report_field("centre_col", head_r.col, rsp_centre_col);
            if (rsp_frame_last !== head_r.last)
               report_field("frame_last", head_r.last, rsp_frame_last);
         end
      end
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   function automatic logic [PIX_W-1:0] pick_pixel(input int style, input logic [PIX_W-1:0] base);
      case (style)
         STYLE_NEAR:   return base + PIX_W'($urandom_range(6)) - 8'd3;
         STYLE_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
         default:      return PIX_W'($urandom);
      endcase
   endfunction

   // Hold the payload until the transfer, then predict; valid is left high for the caller.
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic first);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel       <= pix;
      req_frame_start <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pixel(pix, first);
   endtask

   task automatic send_run(input int count, input int style, input logic first,
                           input int stray_pct);
      logic [PIX_W-1:0] base;
      base = PIX_W'($urandom);
      for (int i = 0; i < count; i++)
         send_pixel(pick_pixel(style, base),
                    (first && i == 0) || ($urandom_range(999) < stray_pct));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_labels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_geometry(input int unsigned width, input int unsigned height,
                                 input int unsigned bias);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_LINE_WIDTH;
      csr_wdata    <= CSR_W'(width);
      @(posedge clock);
      csr_index    <= CSR_FRAME_HEIGHT;
      csr_wdata    <= CSR_W'(height);
      @(posedge clock);
      csr_index    <= CSR_THRESHOLD_BIAS;
      csr_wdata    <= CSR_W'(bias & 8'hFF);
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_line_width   = width & 12'hFFF;
      cfg_frame_height = height & 12'hFFF;
      cfg_bias         = 8'(bias);
      @(posedge clock);
   endtask

   // Default geometry straight out of reset: a stretch of the first row, which gives no label.
   task automatic test_reset_geometry();
      sender_idle_pct    = 20;
      receiver_stall_pct = 20;
      send_run(LINE_WIDTH_RESET / 8, STYLE_ANY, 1'b1, 0);
      wait_idle();
   endtask

   task automatic test_directed_windows();
      // saturated ring, a peak no neighbour exceeds, then a folded non-uniform code; frame_last on the third
      logic [PIX_W-1:0] frame_a [15] = '{8'd255, 8'd255, 8'd255,
                                         8'd255, 8'd0,   8'd255,
                                         8'd255, 8'd255, 8'd255,
                                         8'd0,   8'd200, 8'd0,
                                         8'd0,   8'd255, 8'd0};
      // threshold wraps below the centre; two opposite corners alone exceed it
      logic [PIX_W-1:0] frame_b [9]  = '{8'd10, 8'd9,  8'd9,
                                         8'd9,  8'd10, 8'd9,
                                         8'd9,  8'd9,  8'd10};
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      write_geometry(3, 5, 0);
      for (int i = 0; i < 15; i++) send_pixel(frame_a[i], i == 0);
      wait_idle();
      write_geometry(3, 3, 255);
      for (int i = 0; i < 9; i++) send_pixel(frame_b[i], i == 0);
      wait_idle();
   endtask

   // Widths or heights below three: the counters wrap but no window completes.
   task automatic test_tiny_geometry();
      sender_idle_pct    = 10;
      receiver_stall_pct = 10;
      for (int k = 0; k < 6; k++) begin
         write_geometry((k < 3) ? k : 5, (k < 3) ? 5 : k - 3, $urandom_range(255));
         send_run(12, STYLE_ANY, 1'b1, 0);
         wait_idle();
      end
   endtask

   task automatic test_mid_frame_change();
      sender_idle_pct    = 10;
      receiver_stall_pct = 30;
      write_geometry(8, 8, 3);
      send_run(30, STYLE_NEAR, 1'b1, 0);
      wait_idle();
      // shrink the row under the current column: one dead pixel, then wrap to the next row
      write_geometry(4, 8, 3);
      send_run(13, STYLE_NEAR, 1'b0, 0);
      wait_idle();
      // shrink the frame under the current row: the row restarts from zero
      write_geometry(4, 3, 3);
      send_run(14, STYLE_NEAR, 1'b0, 0);
      wait_idle();
   endtask

   task automatic test_geometry_extremes();
      sender_idle_pct    = 5;
      receiver_stall_pct = 5;
      write_geometry(MAX_WIDTH_DEFAULT, 3, $urandom_range(4));
      send_run(64, STYLE_NEAR, 1'b1, 0);
      wait_idle();
      // height beyond the store depth acts as the maximum
      write_geometry(3, 4095, $urandom_range(4));
      send_run(3 * 24, STYLE_NEAR, 1'b1, 0);
      wait_idle();
      write_geometry(4095, 3, $urandom_range(255));
      send_run(64, STYLE_ANY, 1'b1, 0);
      wait_idle();
   endtask

   task automatic test_random_frames(input int send_pct, input int stall_pct);
      int unsigned width;
      int unsigned height;
      int unsigned bias;
      int          count;
      int          sent;
      bit          rewrite;
      sender_idle_pct    = send_pct;
      receiver_stall_pct = stall_pct;
      sent    = 0;
      rewrite = 1'b1;
      width   = 3;
      height  = 3;
      while (sent < RANDOM_QUOTA) begin
         if (rewrite) begin
            width  = ($urandom_range(19) == 0) ? $urandom_range(80, 13) : $urandom_range(12, 3);
            height = $urandom_range(8, 3);
            case ($urandom_range(3))
               0:       bias = 0;
               1:       bias = 255;
               2:       bias = $urandom_range(255);
               default: bias = $urandom_range(4);
            endcase
            wait_idle();
            write_geometry(width, height, bias);
         end
         count = width * height;
         case ($urandom_range(7))
            0:       count = $urandom_range(count - 1, 1);
            1:       count = count + $urandom_range(2 * width, 1);
            default: ;
         endcase
         // a fresh frame is marked whenever the geometry changed; otherwise now and then
         send_run(count, $urandom_range(STYLE_BINARY),
                  rewrite || ($urandom_range(1) == 0), 10);
         sent    = sent + count;
         rewrite = ($urandom_range(3) != 0);
      end
   endtask

   initial begin
      int tail;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_geometry();
      test_directed_windows();
      test_tiny_geometry();
      test_mid_frame_change();
      test_geometry_extremes();
      test_random_frames(6, 66);
      test_random_frames(66, 6);
      test_random_frames(0, 0);

      req_valid <= 1'b0;
      @(posedge clock);
      tail = 0;
      while (pending_labels.size() != 0 && tail < DRAIN_LIMIT) begin
         @(posedge clock);
         tail++;
      end
      if (pending_labels.size() != 0) begin
         fault_count++;
         $display("%0t: %0d expected labels never arrived", $time, pending_labels.size());
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("** lbp_nr_uniform_3x3_core: PASSED **");
      end else begin
         $display("** lbp_nr_uniform_3x3_core: FAILED **");
      end
      $finish;
   end

endmodule
